@@ rtl/mct_pkg.sv @@
// Package with the shared types and constants of the multistage capture trigger.
`timescale 1ns / 1ps
`default_nettype none

package mct_pkg;

  // Probe count and the mask of probe bits that take part in matching.
  localparam int unsigned PROBES = 8;
  localparam logic [7:0] PROBE_BITS = (PROBES >= 8) ? 8'hFF : 8'((1 << PROBES) - 1);

  // Stages that have fields in the configuration registers.
  localparam int unsigned REG_STAGES = 4;

  // Width of pattern lengths and result positions (values up to REG_STAGES + 2).
  localparam int unsigned KW = 3;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_TRIGGER = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_MASKS  = 2'd0;
  localparam logic [1:0] REG_VALUES = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned CNT_W  = 33;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] probe_levels;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] value;
  } stage_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/mct_cell.sv @@
// One history cell: holds an earlier sample and checks it against its trigger stage.
`timescale 1ns / 1ps
`default_nettype none

module mct_cell
  import mct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic [7:0] din,
  input  wire logic       din_vld,
  input  wire stage_t     stage,
  input  wire logic       en,
  output logic      [7:0] dout,
  output logic            dout_vld,
  output logic            ok
);

  logic [7:0] hist_r;
  logic       vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.clear) begin
      vld_r <= 1'b0;
    end else if (ctrl.shift) begin
      vld_r <= din_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hist_r <= din;
    end
  end

  // A cell outside the current pattern never blocks a match.
  assign ok       = !en || (vld_r && ((hist_r & stage.mask) == stage.value));
  assign dout     = hist_r;
  assign dout_vld = vld_r;

endmodule

`default_nettype wire

@@ rtl/multistage_capture_trigger.sv @@
// Top level of the multistage capture trigger: control, history chain and result queue.
// Latency: the first result of a transaction is offered in the cycle after it is accepted.
// Throughput: one input transaction per cycle while each yields at most one result and the
// result channel does not stall; a transaction yielding n results (up to pattern length plus
// two) holds the input until its last result leaves, one result per cycle while not stalled.
// Reset: synchronous, active low; clears the registers, control state and history valid bits.
`timescale 1ns / 1ps
`default_nettype none

module multistage_capture_trigger
  import mct_pkg::*;
#(
  parameter int unsigned STAGES = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  // Only the stages that have register fields can ever hold a nonzero mask, so the
  // pattern is at most KMAX samples long. The current sample is the newest window
  // entry, so the history chain needs one cell fewer than that.
  localparam int unsigned KMAX = (STAGES < REG_STAGES) ? STAGES : REG_STAGES;
  localparam int unsigned NC   = KMAX - 1;
  localparam int unsigned NCA  = (NC > 0) ? NC : 1;
  localparam int unsigned NBUF = KMAX + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is always high, so every access completes in
  // its access cycle. Only bits [3:2] of the address select a register.
  // ---------------------------------------------------------------------------
  logic [31:0] masks_r;
  logic [31:0] values_r;
  logic [31:0] limit_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r  <= '0;
      values_r <= '0;
      limit_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MASKS:  masks_r  <= pwdata;
        REG_VALUES: values_r <= pwdata;
        REG_LIMIT:  limit_r  <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MASKS:  prdata = masks_r;
      REG_VALUES: prdata = values_r;
      REG_LIMIT:  prdata = limit_r;
      default:    prdata = '0;
    endcase
  end

  // Per-stage mask and required value; probe bits above the probe count are ignored
  // in the mask only, so a value bit outside the mask makes its stage unmatchable.
  stage_t stg [REG_STAGES];

  always_comb begin
    for (int s = 0; s < REG_STAGES; s++) begin
      stg[s].mask  = masks_r[8*s +: 8] & PROBE_BITS;
      stg[s].value = values_r[8*s +: 8];
    end
  end

  // Pattern length: the number of leading stages with a nonzero mask.
  logic [KW-1:0] k;

  always_comb begin
    logic stop;
    k    = '0;
    stop = 1'b0;
    for (int s = 0; s < KMAX; s++) begin
      if (!stop && (stg[s].mask != 8'h00)) begin
        k = k + 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes. A new transaction is taken when the result queue is empty, or when
  // its one remaining result leaves in this same cycle.
  // ---------------------------------------------------------------------------
  out_item_t     q_r [NBUF];
  out_item_t     q_nxt [NBUF];
  logic [KW-1:0] q_cnt_r;
  logic [KW-1:0] q_cnt_nxt;
  logic          in_fire;
  logic          out_fire;

  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_r[0];
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = !((q_cnt_r == '0) || ((q_cnt_r == KW'(1)) && !out_stall));
  assign in_fire   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // History chain. Cell c holds the sample taken c + 1 samples ago and, for the
  // current pattern length, is checked against stage k - 2 - c.
  // ---------------------------------------------------------------------------
  cell_ctrl_t  cctrl;
  logic [7:0]  x;
  logic [7:0]  cell_dout [NCA];
  logic        cell_vld  [NCA];
  logic        cell_ok   [NCA];

  assign x = in_data.probe_levels & PROBE_BITS;

  generate
    if (NC > 0) begin : g_chain
      for (genvar c = 0; c < NC; c++) begin : g_cell
        logic [KW-1:0] sidx;
        logic [7:0]    din;
        logic          din_vld;
        logic          en;

        assign sidx = k - KW'(2) - KW'(c);
        assign en   = (k >= KW'(c + 2));

        if (c == 0) begin : g_head
          assign din     = x;
          assign din_vld = 1'b1;
        end else begin : g_body
          assign din     = cell_dout[c-1];
          assign din_vld = cell_vld[c-1];
        end

        mct_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (cctrl),
          .din      (din),
          .din_vld  (din_vld),
          .stage    (stg[sidx[1:0]]),
          .en       (en),
          .dout     (cell_dout[c]),
          .dout_vld (cell_vld[c]),
          .ok       (cell_ok[c])
        );
      end
    end else begin : g_no_chain
      // A single-stage pattern compares the current sample alone.
      assign cell_dout[0] = 8'h00;
      assign cell_vld[0]  = 1'b0;
      assign cell_ok[0]   = 1'b1;
    end
  endgenerate

  // The window matches when the current sample fits the last stage and every cell
  // inside the pattern is filled and fits its own stage.
  logic [KW-1:0] km1;
  logic          hit;

  assign km1 = k - KW'(1);

  always_comb begin
    hit = ((x & stg[km1[1:0]].mask) == stg[km1[1:0]].value);
    for (int c = 0; c < NCA; c++) begin
      hit = hit && cell_ok[c];
    end
  end

  // ---------------------------------------------------------------------------
  // Capture control.
  // ---------------------------------------------------------------------------
  logic             running_r;
  logic             running_nxt;
  logic             fired_r;
  logic             fired_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_add;
  logic [CNT_W:0]   count_sum;
  logic             has_trig;
  logic             has_end;
  logic [KW-1:0]    n_data;
  logic [KW-1:0]    res_n;

  // Forwarded samples are counted with saturation at the counter's full range.
  assign count_sum = {1'b0, count_r} + (CNT_W + 1)'(n_data);
  assign count_add = count_sum[CNT_W] ? '1 : count_sum[CNT_W-1:0];

  always_comb begin
    running_nxt = running_r;
    fired_nxt   = fired_r;
    count_nxt   = count_r;
    has_trig    = 1'b0;
    has_end     = 1'b0;
    n_data      = '0;
    cctrl       = '0;
    if (in_fire) begin
      case (in_data.op)
        OP_START: begin
          cctrl.clear = 1'b1;
          count_nxt   = '0;
          running_nxt = 1'b1;
          fired_nxt   = (k == '0);
        end
        OP_STOP: begin
          if (running_r) begin
            has_end     = 1'b1;
            running_nxt = 1'b0;
          end
        end
        OP_SAMPLE: begin
          if (running_r) begin
            if (fired_r || (k == '0)) begin
              // Already triggered, or an empty pattern: plain forwarding.
              n_data    = KW'(1);
              fired_nxt = 1'b1;
            end else if (hit) begin
              // Marker first, then the whole window oldest first.
              has_trig  = 1'b1;
              n_data    = k;
              fired_nxt = 1'b1;
            end else begin
              cctrl.shift = 1'b1;
            end
            if (n_data != '0) begin
              count_nxt = count_add;
              if ((limit_r != 32'd0) && (count_add > {1'b0, limit_r})) begin
                has_end     = 1'b1;
                running_nxt = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_n = KW'(has_trig) + n_data + KW'(has_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      fired_r   <= 1'b0;
      count_r   <= '0;
    end else begin
      running_r <= running_nxt;
      fired_r   <= fired_nxt;
      count_r   <= count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. An accepted transaction loads its whole burst of results; the
  // head is offered on the result channel and the queue shifts by one on every
  // completed result transaction.
  // ---------------------------------------------------------------------------
  out_item_t res [NBUF];

  always_comb begin
    logic [KW-1:0] base;
    logic [KW-1:0] pos;
    logic [KW-1:0] d;
    logic [KW-1:0] hidx;
    logic [7:0]    w;
    base = KW'(has_trig);
    for (int j = 0; j < NBUF; j++) begin
      pos  = KW'(j);
      d    = pos - base;
      hidx = k - KW'(2) - d;
      w    = 8'h00;
      for (int c = 0; c < NCA; c++) begin
        if (hidx == KW'(c)) begin
          w = cell_dout[c];
        end
      end
      if (d == n_data - KW'(1)) begin
        w = x;
      end
      res[j] = '0;
      if (has_trig && (pos == '0)) begin
        res[j].kind = KIND_TRIGGER;
      end else if ((pos >= base) && (pos < base + n_data)) begin
        res[j].kind      = KIND_DATA;
        res[j].data_byte = w;
      end else if (has_end && (pos == base + n_data)) begin
        res[j].kind = KIND_END;
      end
      res[j].last = (pos == res_n - KW'(1));
    end
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    for (int j = 0; j < NBUF; j++) begin
      q_nxt[j] = q_r[j];
    end
    if (in_fire) begin
      q_cnt_nxt = res_n;
      for (int j = 0; j < NBUF; j++) begin
        q_nxt[j] = res[j];
      end
    end else if (out_fire) begin
      q_cnt_nxt = q_cnt_r - KW'(1);
      for (int j = 0; j < NBUF - 1; j++) begin
        q_nxt[j] = q_r[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NBUF; j++) begin
      q_r[j] <= q_nxt[j];
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_multistage_capture_trigger.sv @@
// Self-checking testbench for the multistage capture trigger: directed cases, random captures.
`timescale 1ns / 1ps
`default_nettype none

module tb_multistage_capture_trigger;
  import mct_pkg::*;

  // Depth of the sample history that the trigger window draws on.
  localparam int unsigned HIST_DEPTH    = 3;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int unsigned IDLE_LIMIT    = 3000;
  // The first result comes in the cycle after acceptance, so a few cycles cover anything in flight.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Length of the long receiver hold-off that fills the block.
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam logic [32:0] COUNT_SAT     = '1;
  // The one operation code that the block ignores.
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  // Receiver stall patterns.
  localparam int unsigned RX_FREE    = 0;
  localparam int unsigned RX_LIGHT   = 1;
  localparam int unsigned RX_HEAVY   = 2;
  localparam int unsigned RX_TOGGLE  = 3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  multistage_capture_trigger u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Trigger model. It holds its own copy of the registers and of the capture
  // state, and turns each accepted input transaction into the results that the
  // block should deliver, appended to the queue of pending captures.
  // ---------------------------------------------------------------------------
  logic [31:0] trig_masks  = '0;
  logic [31:0] trig_values = '0;
  logic [31:0] cap_limit   = '0;
  logic [7:0]  probe_hist [HIST_DEPTH] = '{default: 8'h00};
  int unsigned hist_fill   = 0;
  bit          trig_fired  = 1'b0;
  bit          capture_on  = 1'b0;
  logic [32:0] fwd_count   = '0;

  out_item_t   pending_captures [$];
  out_item_t   step_results [$];

  int unsigned mismatches     = 0;
  int unsigned useful_items   = 0;
  int unsigned results_seen   = 0;
  int unsigned markers_seen   = 0;
  int unsigned ends_seen      = 0;
  int unsigned settings_used  = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned burst_left     = 0;

  function automatic logic [7:0] stage_mask(input int s);
    return (s < REG_STAGES) ? (trig_masks[8*s +: 8] & PROBE_BITS) : 8'h00;
  endfunction

  function automatic logic [7:0] stage_value(input int s);
    return (s < REG_STAGES) ? trig_values[8*s +: 8] : 8'h00;
  endfunction

  // Pattern length: the run of leading stages whose mask is not empty.
  function automatic int pattern_length();
    int k;
    k = 0;
    while (k < REG_STAGES && stage_mask(k) != 8'h00)
      k++;
    return k;
  endfunction

  // Window position s of a pattern of length k: 0 is the oldest sample, k-1 the current one.
  function automatic logic [7:0] window_sample(input int s, input int k, input logic [7:0] x);
    return (s == k - 1) ? x : probe_hist[k - 2 - s];
  endfunction

  function automatic void emit_result(input logic [1:0] kind, input logic [7:0] data);
    out_item_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.last      = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void forward_sample(input logic [7:0] data);
    emit_result(KIND_DATA, data);
    if (fwd_count != COUNT_SAT)
      fwd_count++;
  endfunction

  // A nonzero limit that has been passed ends the capture.
  function automatic void enforce_limit();
    if (cap_limit != 32'd0 && fwd_count > {1'b0, cap_limit}) begin
      emit_result(KIND_END, 8'h00);
      capture_on = 1'b0;
    end
  endfunction

  function automatic void push_history(input logic [7:0] x);
    for (int i = HIST_DEPTH - 1; i > 0; i--)
      probe_hist[i] = probe_hist[i - 1];
    probe_hist[0] = x;
    if (hist_fill < HIST_DEPTH)
      hist_fill++;
  endfunction

  function automatic void predict_capture(input in_item_t item);
    logic [7:0] x;
    int         k;
    int         s;
    bit         hit;
    step_results.delete();
    x = item.probe_levels & PROBE_BITS;
    case (item.op)
      OP_START: begin
        foreach (probe_hist[i])
          probe_hist[i] = 8'h00;
        hist_fill  = 0;
        fwd_count  = '0;
        capture_on = 1'b1;
        trig_fired = (pattern_length() == 0);
      end
      OP_STOP: begin
        if (capture_on) begin
          emit_result(KIND_END, 8'h00);
          capture_on = 1'b0;
        end
      end
      OP_SAMPLE: begin
        if (capture_on) begin
          k = pattern_length();
          if (trig_fired) begin
            forward_sample(x);
            enforce_limit();
          end else if (k == 0) begin
            // The pattern was emptied by a register write while armed.
            trig_fired = 1'b1;
            forward_sample(x);
            enforce_limit();
          end else if (hist_fill + 1 >= k) begin
            hit = 1'b1;
            for (s = 0; s < k; s++)
              if ((window_sample(s, k, x) & stage_mask(s)) != stage_value(s))
                hit = 1'b0;
            if (hit) begin
              emit_result(KIND_TRIGGER, 8'h00);
              for (s = 0; s < k; s++)
                forward_sample(window_sample(s, k, x));
              trig_fired = 1'b1;
              enforce_limit();
            end else begin
              push_history(x);
            end
          end else begin
            push_history(x);
          end
        end
      end
      default: begin
      end
    endcase
    if (step_results.size() != 0)
      step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i])
      pending_captures.push_back(step_results[i]);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Transactions go out in bursts of random length, with random gaps
  // between the bursts. valid stays high from one transaction to the next within
  // a burst; only the payload changes.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [7:0] levels);
    in_item_t item;
    item.op           = op;
    item.probe_levels = levels;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do
      @(posedge clk);
    while (in_stall);
    if (op == OP_START || (capture_on && op != OP_UNUSED))
      useful_items++;
    predict_capture(item);
    burst_left--;
  endtask

  // Stops offering input, waits for every pending result and then lets the block settle.
  task automatic drain_results();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_captures.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read-back on the configuration port.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    case (idx)
      REG_MASKS:  trig_masks  = value;
      REG_VALUES: trig_values = value;
      REG_LIMIT:  cap_limit   = value;
      default: begin
      end
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== value)
      report_mismatch($sformatf("register %0d reads %08h, wrote %08h", idx, readback, value));
    settings_used++;
  endtask

  task automatic write_settings(input logic [31:0] masks, input logic [31:0] values,
                                input logic [31:0] limit);
    write_register(REG_MASKS, masks);
    write_register(REG_VALUES, values);
    write_register(REG_LIMIT, limit);
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The receiver stalls on patterns of its own, each kept for a random
  // span, and serves a long hold-off whenever a test asks for one.
  // ---------------------------------------------------------------------------
  int unsigned rx_mode = RX_FREE;
  int unsigned rx_span = 0;
  int unsigned rx_hold = 0;

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold    = rx_hold - 1;
    end else if (hold_requests != holds_served) begin
      out_stall   <= 1'b1;
      rx_hold      = LONG_HOLD;
      holds_served = holds_served + 1;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_TOGGLE);
        rx_span = $urandom_range(8, 60);
      end
      rx_span = rx_span - 1;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // Each delivered result is compared with the oldest pending one, field by field.
  out_item_t oldest_capture;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.kind == KIND_TRIGGER)
        markers_seen++;
      if (out_data.kind == KIND_END)
        ends_seen++;
      if (pending_captures.size() == 0) begin
        report_mismatch($sformatf("result kind %0d data %02h last %0b with nothing pending",
                                  out_data.kind, out_data.data_byte, out_data.last));
      end else begin
        oldest_capture = pending_captures.pop_front();
        if (out_data.kind !== oldest_capture.kind)
          report_mismatch($sformatf("kind %0d, expected %0d",
                                    out_data.kind, oldest_capture.kind));
        if (out_data.data_byte !== oldest_capture.data_byte)
          report_mismatch($sformatf("data_byte %02h, expected %02h",
                                    out_data.data_byte, oldest_capture.data_byte));
        if (out_data.last !== oldest_capture.last)
          report_mismatch($sformatf("last %0b, expected %0b",
                                    out_data.last, oldest_capture.last));
      end
    end
  end

  // Watchdog: a long run of cycles in which no transaction moves means the block has hung.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results still pending.",
                 IDLE_LIMIT, pending_captures.size());
        $display("FAIL multistage_capture_trigger");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // While idle, samples, stops and the unused code must all be swallowed silently.
  task automatic test_idle_ignored();
    send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_STOP, 8'h00);
    send_item(OP_UNUSED, 8'h00);
    drain_results();
  endtask

  // An empty pattern fires at start without a marker and forwards everything.
  task automatic test_empty_pattern();
    write_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_START, 8'h00);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_STOP, 8'hFF);
    drain_results();
  endtask

  // All four stages in use with every probe; the first samples see a short history.
  task automatic test_full_pattern();
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_START, 8'hFF);
    repeat (4) send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_STOP, 8'h00);
    drain_results();
  endtask

  // A match broken half way must restart the search, and a limit of one ends the
  // capture straight after the trigger window, which gives the longest result burst.
  task automatic test_restart_and_limit();
    write_settings(32'h0F0F_0F0F, 32'h0403_0201, 32'h0000_0001);
    send_item(OP_START, 8'h00);
    send_item(OP_SAMPLE, 8'hF1);
    send_item(OP_SAMPLE, 8'h02);
    send_item(OP_SAMPLE, 8'h01);
    send_item(OP_SAMPLE, 8'h32);
    send_item(OP_SAMPLE, 8'h03);
    send_item(OP_SAMPLE, 8'hA4);
    drain_results();
  endtask

  // A required level outside the stage mask can never be met.
  task automatic test_value_outside_mask();
    write_settings(32'h0000_000F, 32'h0000_0010, 32'h0000_0000);
    send_item(OP_START, 8'h00);
    send_item(OP_SAMPLE, 8'h10);
    send_item(OP_STOP, 8'h00);
    drain_results();
  endtask

  // Re-arming while running, then register writes that land during a capture: the
  // pattern is emptied while armed and later the limit is tightened to the current count.
  task automatic test_writes_while_armed();
    write_settings(32'h0000_00FF, 32'h0000_00AA, 32'h0000_0000);
    send_item(OP_START, 8'h00);
    send_item(OP_SAMPLE, 8'h55);
    send_item(OP_START, 8'h00);
    send_item(OP_UNUSED, 8'hAA);
    drain_results();
    write_register(REG_MASKS, 32'h0000_0000);
    send_item(OP_SAMPLE, 8'h33);
    drain_results();
    write_register(REG_LIMIT, 32'h0000_0001);
    send_item(OP_SAMPLE, 8'h44);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so the
  // block fills and stalls its input; then the sender waits for every result.
  task automatic test_backpressure();
    write_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_START, 8'h00);
    hold_requests++;
    burst_left = 40;
    repeat (30) send_item(OP_SAMPLE, 8'($urandom));
    drain_results();
  endtask

  // Random captures: each phase picks a setting, then mostly sends well-formed
  // trigger sequences with random don't-care bits, mixed with noise, broken
  // sequences, stops, re-arms and the unused code.
  task automatic test_random_captures(input int unsigned target);
    logic [31:0] masks;
    logic [31:0] values;
    logic [31:0] limit;
    logic [7:0]  m;
    logic [7:0]  v;
    int          k;
    int          s;
    int          run;
    int unsigned phase_len;
    int unsigned phase_base;
    int unsigned pick;
    bit          paused;
    while (useful_items < target) begin
      k = $urandom_range(0, REG_STAGES);
      masks  = '0;
      values = '0;
      for (s = 0; s < REG_STAGES; s++) begin
        if ($urandom_range(0, 3) == 0)
          m = 8'h01 << $urandom_range(0, 7);
        else
          m = 8'($urandom_range(1, 255));
        // Stages behind the first empty one must not count, whatever they hold.
        if (s == k || (s > k && $urandom_range(0, 1) == 0))
          m = 8'h00;
        v = 8'($urandom_range(0, 255));
        masks[8*s +: 8]  = m;
        values[8*s +: 8] = ($urandom_range(0, 7) == 0) ? v : (v & m);
      end
      case ($urandom_range(0, 7))
        0, 1:    limit = 32'd0;
        2:       limit = 32'hFFFF_FFFF;
        3:       limit = $urandom;
        default: limit = $urandom_range(1, 12);
      endcase
      write_settings(masks, values, limit);
      phase_len  = $urandom_range(20, 60);
      phase_base = useful_items;
      paused     = ($urandom_range(0, 2) != 0);
      send_item(OP_START, 8'($urandom));
      while (useful_items - phase_base < phase_len) begin
        pick = $urandom_range(0, 99);
        if (!paused && useful_items - phase_base >= phase_len / 2) begin
          paused = 1'b1;
          drain_results();
        end
        if (!capture_on && pick < 70) begin
          send_item(OP_START, 8'($urandom));
        end else if (pick < 4) begin
          send_item(OP_START, 8'($urandom));
        end else if (pick < 8) begin
          send_item(OP_STOP, 8'($urandom));
        end else if (pick < 11) begin
          send_item(OP_UNUSED, 8'($urandom));
        end else if (pick < 55 && k > 0) begin
          run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, k) : k;
          for (s = 0; s < run; s++)
            send_item(OP_SAMPLE, (8'($urandom) & ~masks[8*s +: 8]) | values[8*s +: 8]);
        end else begin
          send_item(OP_SAMPLE, 8'($urandom));
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ignored();
    test_empty_pattern();
    test_full_pattern();
    test_restart_and_limit();
    test_value_outside_mask();
    test_writes_while_armed();
    test_backpressure();
    test_random_captures(useful_items + 270);
    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d effective input transactions under %0d register writes,",
             useful_items, settings_used);
    $display("checking %0d results: %0d trigger markers and %0d end markers.",
             results_seen, markers_seen, ends_seen);
    if (mismatches == 0) begin
      $display("PASS multistage_capture_trigger");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("FAIL multistage_capture_trigger");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/mct_pkg.sv
rtl/mct_cell.sv
rtl/multistage_capture_trigger.sv
tb/tb_multistage_capture_trigger.sv
